FILE: rtl/lru_page_replacement_assert.svh
// Assertion macros for the LRU page replacement block.
// Depends on nothing; included by the top level, which supplies clk and rst.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked outside reset.
`define LRUPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define LRUPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRUPR_ASSERT(lbl, prop, msg)
`define LRUPR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement block.
// No dependencies.
package lrupr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int CFG_W      = 5;
  localparam int FAULT_W    = 32;
  localparam int ADDR_W     = 3;

  // register index of frames_in_use
  localparam logic [0:0] REG_FRAMES = 1'b0;
  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(MAX_FRAMES);

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;    // latch the reference and its match vector
    logic commit;  // update stack and write the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic rsp_busy;  // result register full and stalled
  } dp_status_t;

endpackage

FILE: rtl/lrupr_ctrl.sv
// Controller for the LRU page replacement block: two-state sequencer.
// Depends on lrupr_pkg.
module lrupr_ctrl
  import lrupr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!status.rsp_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        // no transfer is taken while in reset
        req_stall = rst;
        cmd.load  = req_valid && !rst;
      end
      ST_UPDATE: begin
        cmd.commit = !status.rsp_busy;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/lrupr_dp.sv
// Datapath for the LRU page replacement block: recency stack, match,
// fault counter and result register. Depends on lrupr_pkg.
module lrupr_dp
  import lrupr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           status,
  input  logic [CFG_W-1:0]     frames_in_use,
  input  logic [PAGE_BITS-1:0] page_number,
  input  logic                 last_reference,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic                 page_fault,
  output logic                 evicted_valid,
  output logic [15:0]          evicted_page,
  output logic [FAULT_W-1:0]   fault_total,
  output logic                 string_done
);

  logic [PAGE_BITS-1:0] stack [MAX_FRAMES];  // entry 0 is LRU
  logic [CNT_W-1:0]     count;
  logic [FAULT_W-1:0]   faults;

  logic [PAGE_BITS-1:0] item_page;
  logic                 item_last;
  logic [MAX_FRAMES-1:0] hit_vec;

  logic [CNT_W-1:0]   cap;
  logic               hit;
  logic [IDX_W-1:0]   hit_pos;
  logic               evict;
  logic               do_shift;
  logic [CNT_W-1:0]   shift_from;
  logic [CNT_W-1:0]   wr_pos;
  logic [CNT_W-1:0]   count_next;
  logic [FAULT_W-1:0] faults_next;

  // clamp capacity to 1..MAX_FRAMES
  always_comb begin
    cap = CNT_W'(frames_in_use);
    if (frames_in_use == '0) begin
      cap = CNT_W'(1);
    end else if (CNT_W'(frames_in_use) > CNT_W'(MAX_FRAMES)) begin
      cap = CNT_W'(MAX_FRAMES);
    end
  end

  always_comb begin
    hit     = |hit_vec;
    hit_pos = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_pos = IDX_W'(i);
      end
    end
    evict      = !hit && (count >= cap);
    do_shift   = hit || evict;
    shift_from = hit ? CNT_W'(hit_pos) : '0;
    wr_pos     = do_shift ? count - CNT_W'(1) : count;
    count_next = (!hit && !evict) ? count + CNT_W'(1) : count;
    faults_next = faults;
    if (!hit && (faults != '1)) begin
      faults_next = faults + FAULT_W'(1);
    end
  end

  // reference latch and tag match against live entries
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_page <= page_number;
      item_last <= last_reference;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        hit_vec[i] <= (stack[i] == page_number) && (CNT_W'(i) < count);
      end
    end
  end

  // stack shift; entries at or above count are never read
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (CNT_W'(i) == wr_pos) begin
          stack[i] <= item_page;
        end else if (i < MAX_FRAMES - 1) begin
          if (do_shift && (CNT_W'(i) >= shift_from) && (CNT_W'(i) < wr_pos)) begin
            stack[i] <= stack[i + 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      faults <= '0;
    end else if (cmd.commit) begin
      count  <= item_last ? '0 : count_next;
      faults <= item_last ? '0 : faults_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      page_fault    <= !hit;
      evicted_valid <= evict;
      evicted_page  <= evict ? 16'(stack[0]) : '0;
      fault_total   <= faults_next;
      string_done   <= item_last;
    end
  end

  assign status.rsp_busy = rsp_valid && rsp_stall;

endmodule

FILE: rtl/lru_page_replacement.sv
// Top level of the LRU page replacement block: APB register, controller
// and datapath. Depends on lrupr_pkg, lrupr_ctrl, lrupr_dp and the assert header.
//
//  channel   direction  handshake             payload
//  req       in         req_valid/req_stall   page_number, last_reference
//  rsp       out        rsp_valid/rsp_stall   page_fault, evicted_valid,
//                                             evicted_page, fault_total, string_done
//  apb       in         psel/penable/pready   paddr, pwdata, prdata
//
// For each reference, the accepting edge latches the page and the 16-way tag
// match against the live stack; the commit in the update state shifts the recency
// stack and loads the result register. A new reference waits for that commit.
// The result register holds a finished result while the next reference is taken;
// a commit waits only while that register is full and stalled.
// Reset (rst, synchronous) empties the stack and zeros the fault count;
// frames_in_use returns to 16. A reference marked last clears both again.
`include "lru_page_replacement_assert.svh"

module lru_page_replacement
  import lrupr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // reference in
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [PAGE_BITS-1:0] page_number,
  input  logic                 last_reference,
  // result out
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic                 page_fault,
  output logic                 evicted_valid,
  output logic [15:0]          evicted_page,
  output logic [FAULT_W-1:0]   fault_total,
  output logic                 string_done,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [CFG_W-1:0] frames_in_use;
  logic             cfg_write;
  logic             cfg_hit;
  ctrl_cmd_t        cmd;
  dp_status_t       status;

  assign pready    = 1'b1;
  // word decode; address bits below the word are ignored
  assign cfg_hit   = (paddr[ADDR_W-1:2] == REG_FRAMES);
  assign cfg_write = psel && penable && pwrite && pready && cfg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (cfg_write) begin
      frames_in_use <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = cfg_hit ? {{(32 - CFG_W){1'b0}}, frames_in_use} : '0;

  lrupr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lrupr_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .frames_in_use  (frames_in_use),
    .page_number    (page_number),
    .last_reference (last_reference),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .page_fault     (page_fault),
    .evicted_valid  (evicted_valid),
    .evicted_page   (evicted_page),
    .fault_total    (fault_total),
    .string_done    (string_done)
  );

  // a transfer in is followed by the update cycle, which takes nothing new
  `LRUPR_ASSERT(a_update_blocks, (req_valid && !req_stall) |=> req_stall, "accept during update")
  // a hit never evicts
  `LRUPR_ASSERT(a_hit_no_evict, (rsp_valid && !page_fault) |-> !evicted_valid, "hit with eviction")
  // no eviction reports page zero
  `LRUPR_ASSERT(a_evict_zero, (rsp_valid && !evicted_valid) |-> (evicted_page == '0), "stray page")
  // reset empties the result register
  `LRUPR_ASSERT_ALWAYS(a_rst_empty, rst |=> !rsp_valid, "result valid after reset")

endmodule
